// ===== sv/bej_pkg.sv =====
// ============================================================================
// bej_pkg - shared types and arithmetic for the extension base Jacobian
// Fixed-point widths, pipeline word types and rounding helpers.
// ============================================================================
package bej_pkg;

    localparam int QW    = 16;          // quaternion component, Q1.14
    localparam int PW    = 24;          // tip position, Q.16
    localparam int MW    = 6;           // active dimension mask
    localparam int CW    = 3;           // column index
    localparam int RATW  = 16;          // extension ratio, unsigned Q2.14
    localparam int OW    = 32;          // output entry, Q15.16
    localparam int SQW   = 2 * QW;      // quaternion product
    localparam int R28W  = 34;          // rotation entry before rounding, Q.28
    localparam int RW    = R28W - 14;   // rotation entry, Q.14
    localparam int PRODW = RW + PW;     // rotation times position
    localparam int PSUMW = PRODW + 2;   // sum of three products
    localparam int PPW   = PSUMW - 14;  // rotated position, Q.16
    localparam int XPW   = RW + PPW;    // cross product term
    localparam int XDW   = XPW + 1;     // cross product difference
    localparam int EW    = XDW - 14;    // Jacobian entry before scaling, Q.16
    localparam int HIW   = EW - 16;     // upper part of an entry
    localparam int HPW   = HIW + RATW + 1;
    localparam int LPW   = 16 + RATW;
    localparam int SCW   = 56;          // entry times ratio
    localparam int SRW   = SCW - 14;    // scaled entry before saturation

    localparam int EXT_COLUMNS_DEF = 6;

    localparam logic [RATW-1:0]        RATIO_RESET = 16'd16384;
    localparam logic signed [R28W-1:0] ONE_Q28     = R28W'(1) <<< 28;
    localparam logic signed [OW-1:0]   OUT_MAX     = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0]   OUT_MIN     = {1'b1, {(OW-1){1'b0}}};

    typedef logic signed [QW-1:0]  quat_t;
    typedef logic signed [PW-1:0]  pos_t;
    typedef logic signed [SQW-1:0] sq_t;
    typedef logic signed [RW-1:0]  rent_t;
    typedef logic signed [PPW-1:0] pent_t;
    typedef logic signed [EW-1:0]  ent_t;
    typedef logic signed [OW-1:0]  out_t;

    // rotation matrix r[row][col], rotated position and mask of one pose
    typedef struct packed {
        rent_t [2:0][2:0] r;
        pent_t [2:0]      p;
        logic  [MW-1:0]   mask;
    } pose_t;

    // one column issued by the sequencer
    typedef struct packed {
        logic [CW-1:0] col;
        logic          last;
        logic          active;
        logic          rot;
        rent_t [2:0]   a;
        pent_t [2:0]   p;
    } col_t;

    // unscaled entries of one column: 0..2 linear, 3..5 angular
    typedef struct packed {
        logic [CW-1:0] col;
        logic          last;
        ent_t [5:0]    e;
    } ent_word_t;

    function automatic rent_t rnd_rot(input logic signed [R28W-1:0] v);
        logic signed [R28W-1:0] t;
        t = v + R28W'(8192);
        return t[R28W-1:14];
    endfunction

    function automatic pent_t rnd_pos(input logic signed [PSUMW-1:0] v);
        logic signed [PSUMW-1:0] t;
        t = v + PSUMW'(8192);
        return t[PSUMW-1:14];
    endfunction

    function automatic ent_t rnd_crs(input logic signed [XDW-1:0] v);
        logic signed [XDW-1:0] t;
        t = v + XDW'(8192);
        return t[XDW-1:14];
    endfunction

    function automatic out_t rnd_sat(input logic signed [SCW-1:0] v);
        logic signed [SCW-1:0] t;
        logic signed [SRW-1:0] s;
        t = v + SCW'(8192);
        s = t[SCW-1:14];
        if ((&s[SRW-1:OW-1]) || !(|s[SRW-1:OW-1]))
            return s[OW-1:0];
        else if (s[SRW-1])
            return OUT_MIN;
        else
            return OUT_MAX;
    endfunction

endpackage

// ===== sv/bej_front.sv =====
// ============================================================================
// bej_front - rotation matrix and rotated position pipeline
// Four stages: quaternion products, matrix rounding, matrix times position,
// sum and rounding. Stalls back from the column sequencer.
// ============================================================================
module bej_front
    import bej_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  quat_t          qx,
    input  quat_t          qy,
    input  quat_t          qz,
    input  quat_t          qw,
    input  pos_t           px,
    input  pos_t           py,
    input  pos_t           pz,
    input  logic [MW-1:0]  mask,
    output logic           out_valid,
    input  logic           out_take,
    output pose_t          out_pose
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    sq_t  xx_reg, yy_reg, zz_reg, xy_reg, zw_reg, xz_reg, yw_reg, yz_reg, xw_reg;
    pos_t [2:0]      pos1_reg, pos2_reg;
    logic [MW-1:0]   mask1_reg, mask2_reg, mask3_reg;
    rent_t [2:0][2:0] r2_reg, r3_reg;
    logic signed [PRODW-1:0] prod3_reg [3][3];
    pose_t           pose4_reg;

    logic signed [R28W-1:0] t [3][3];
    rent_t [2:0][2:0] r2_next;
    pent_t [2:0]      p4_next;

    assign adv4     = !v4_reg || out_take;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // stage 1: quaternion products
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            xx_reg    <= qx * qx;
            yy_reg    <= qy * qy;
            zz_reg    <= qz * qz;
            xy_reg    <= qx * qy;
            zw_reg    <= qz * qw;
            xz_reg    <= qx * qz;
            yw_reg    <= qy * qw;
            yz_reg    <= qy * qz;
            xw_reg    <= qx * qw;
            pos1_reg  <= {pz, py, px};
            mask1_reg <= mask;
        end
    end

    // stage 2: rotation matrix in Q.28, rounded to Q.14
    always_comb
    begin
        t[0][0] = ONE_Q28 - ((R28W'(yy_reg) + R28W'(zz_reg)) <<< 1);
        t[0][1] = (R28W'(xy_reg) - R28W'(zw_reg)) <<< 1;
        t[0][2] = (R28W'(xz_reg) + R28W'(yw_reg)) <<< 1;
        t[1][0] = (R28W'(xy_reg) + R28W'(zw_reg)) <<< 1;
        t[1][1] = ONE_Q28 - ((R28W'(xx_reg) + R28W'(zz_reg)) <<< 1);
        t[1][2] = (R28W'(yz_reg) - R28W'(xw_reg)) <<< 1;
        t[2][0] = (R28W'(xz_reg) - R28W'(yw_reg)) <<< 1;
        t[2][1] = (R28W'(yz_reg) + R28W'(xw_reg)) <<< 1;
        t[2][2] = ONE_Q28 - ((R28W'(xx_reg) + R28W'(yy_reg)) <<< 1);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                r2_next[i][j] = rnd_rot(t[i][j]);
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            r2_reg    <= r2_next;
            pos2_reg  <= pos1_reg;
            mask2_reg <= mask1_reg;
        end
    end

    // stage 3: matrix times position, one product per entry
    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    prod3_reg[i][j] <= $signed(r2_reg[i][j]) * $signed(pos2_reg[j]);
            r3_reg    <= r2_reg;
            mask3_reg <= mask2_reg;
        end
    end

    // stage 4: row sums, rounded to Q.16
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            p4_next[i] = rnd_pos(PSUMW'(prod3_reg[i][0]) + PSUMW'(prod3_reg[i][1])
                                 + PSUMW'(prod3_reg[i][2]));
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            pose4_reg.r    <= r3_reg;
            pose4_reg.p    <= p4_next;
            pose4_reg.mask <= mask3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_pose  = pose4_reg;

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_take) |=> (out_valid && $stable(out_pose)))
        else $error("front pipeline dropped or changed a stalled pose");

endmodule

// ===== sv/bej_seq.sv =====
// ============================================================================
// bej_seq - column sequencer
// Holds one pose and issues its columns, one per cycle.
// ============================================================================
module bej_seq
    import bej_pkg::*;
#(
    parameter int EXT_COLUMNS = EXT_COLUMNS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_take,
    input  pose_t  in_pose,
    output logic   col_valid,
    output col_t   col_word
);

    localparam logic [CW-1:0] LAST_COL = CW'(EXT_COLUMNS - 1);
    localparam logic [CW-1:0] ROT_BASE = CW'(3);

    logic          hold_valid_reg, hold_valid_next;
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    pose_t         pose_reg;
    logic          is_rot;
    logic [1:0]    sel;

    // take the next pose once the last column of this one goes out
    assign in_take = !hold_valid_reg || (col_cnt_reg == LAST_COL);

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        col_cnt_next    = col_cnt_reg;
        if (in_take)
        begin
            hold_valid_next = in_valid;
            col_cnt_next    = '0;
        end
        else
            col_cnt_next = col_cnt_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            col_cnt_reg    <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            col_cnt_reg    <= col_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            pose_reg <= in_pose;
    end

    assign is_rot = (col_cnt_reg >= ROT_BASE);
    assign sel    = is_rot ? 2'(col_cnt_reg - ROT_BASE) : col_cnt_reg[1:0];

    always_comb
    begin
        col_word.col    = col_cnt_reg;
        col_word.last   = (col_cnt_reg == LAST_COL);
        col_word.active = pose_reg.mask[col_cnt_reg];
        col_word.rot    = is_rot;
        col_word.p      = pose_reg.p;
        for (int i = 0; i < 3; i++)
            col_word.a[i] = pose_reg.r[i][sel];
    end

    assign col_valid = hold_valid_reg;

    a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (col_cnt_reg <= LAST_COL))
        else $error("column counter ran past the last column");

    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && col_cnt_reg != LAST_COL) |=>
        (hold_valid_reg && col_cnt_reg == $past(col_cnt_reg) + CW'(1)))
        else $error("column sequence skipped or repeated a column");

endmodule

// ===== sv/bej_cross.sv =====
// ============================================================================
// bej_cross - column entry builder
// Two stages: cross product terms, then differences, masking and selection.
// ============================================================================
module bej_cross
    import bej_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  col_t       in_col,
    output logic       out_valid,
    output ent_word_t  out_word
);

    logic v1_reg, v2_reg;
    col_t col1_reg;
    logic signed [XPW-1:0] m_reg [6];
    ent_word_t word2_reg;
    ent_word_t word2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // r x p terms
    always_ff @(posedge clk)
    begin
        col1_reg <= in_col;
        m_reg[0] <= $signed(in_col.a[1]) * $signed(in_col.p[2]);
        m_reg[1] <= $signed(in_col.a[2]) * $signed(in_col.p[1]);
        m_reg[2] <= $signed(in_col.a[2]) * $signed(in_col.p[0]);
        m_reg[3] <= $signed(in_col.a[0]) * $signed(in_col.p[2]);
        m_reg[4] <= $signed(in_col.a[0]) * $signed(in_col.p[1]);
        m_reg[5] <= $signed(in_col.a[1]) * $signed(in_col.p[0]);
    end

    always_comb
    begin
        word2_next.col  = col1_reg.col;
        word2_next.last = col1_reg.last;
        word2_next.e    = '0;
        if (col1_reg.active)
        begin
            if (col1_reg.rot)
            begin
                for (int i = 0; i < 3; i++)
                    word2_next.e[i] = rnd_crs(XDW'(m_reg[2*i]) - XDW'(m_reg[2*i+1]));
                for (int i = 0; i < 3; i++)
                    word2_next.e[3+i] = EW'($signed(col1_reg.a[i])) <<< 2;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                    word2_next.e[i] = EW'($signed(col1_reg.a[i])) <<< 2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word2_reg <= word2_next;
    end

    assign out_valid = v2_reg;
    assign out_word  = word2_reg;

endmodule

// ===== sv/bej_scale.sv =====
// ============================================================================
// bej_scale - ratio scaling and saturation
// Split multiply by the extension ratio, then combine, round and saturate
// into the result registers.
// ============================================================================
module bej_scale
    import bej_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  ent_word_t       in_word,
    input  logic [RATW-1:0] ratio,
    output logic            out_valid,
    output logic [CW-1:0]   out_col,
    output logic            out_last,
    output out_t [5:0]      out_e
);

    logic v1_reg, v2_reg;
    logic [CW-1:0] col1_reg, col2_reg;
    logic          last1_reg, last2_reg;
    logic signed [HPW-1:0] hi_reg [6];
    logic [LPW-1:0]        lo_reg [6];
    out_t [5:0] e2_reg;
    out_t [5:0] e2_next;
    logic signed [RATW:0] ratio_s;

    assign ratio_s = $signed({1'b0, ratio});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // partial products: signed upper part and unsigned low 16 bits
    always_ff @(posedge clk)
    begin
        col1_reg  <= in_word.col;
        last1_reg <= in_word.last;
        for (int k = 0; k < 6; k++)
        begin
            hi_reg[k] <= $signed(in_word.e[k][EW-1:16]) * ratio_s;
            lo_reg[k] <= in_word.e[k][15:0] * ratio;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
            e2_next[k] = rnd_sat((SCW'(hi_reg[k]) <<< 16)
                                 + $signed({{(SCW-LPW){1'b0}}, lo_reg[k]}));
    end

    always_ff @(posedge clk)
    begin
        col2_reg  <= col1_reg;
        last2_reg <= last1_reg;
        e2_reg    <= e2_next;
    end

    assign out_valid = v2_reg;
    assign out_col   = col2_reg;
    assign out_last  = last2_reg;
    assign out_e     = e2_reg;

endmodule

// ===== sv/base_extension_jacobian.sv =====
// ============================================================================
// base_extension_jacobian - six-column Jacobian of a mobile extension base
// Rotation matrix from a unit quaternion, rotated tip position, and six
// masked, ratio-scaled, saturated Jacobian columns per pose.
// ============================================================================
//
//  channel   handshake                 word
//  -------   -----------------------   ------------------------------------
//  pose in   start / busy              quat_x..w, pos_x..z, active_mask
//  config    cfg_valid / cfg_ready     cfg_data (extension ratio)
//  column    result_valid strobe       column, row_vx..row_wz, last_column
//
//  A pose is taken when start is high and busy is low; it yields six columns,
//  one per cycle. The column sequencer emits them and takes the next pose
//  only once the last column of the current one goes out; poses queue in
//  the four-stage front pipeline meanwhile, and busy rises when it fills.
//  Reset clears all valid state and loads the ratio with 1.0.
//  The column output cannot be stalled; cfg_ready is always high.
//
module base_extension_jacobian
    import bej_pkg::*;
#(
    parameter int EXT_COLUMNS = EXT_COLUMNS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  quat_t           quat_x,
    input  quat_t           quat_y,
    input  quat_t           quat_z,
    input  quat_t           quat_w,
    input  pos_t            pos_x,
    input  pos_t            pos_y,
    input  pos_t            pos_z,
    input  logic [MW-1:0]   active_mask,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [RATW-1:0] cfg_data,
    output logic            result_valid,
    output logic [CW-1:0]   column,
    output out_t            row_vx,
    output out_t            row_vy,
    output out_t            row_vz,
    output out_t            row_wx,
    output out_t            row_wy,
    output out_t            row_wz,
    output logic            last_column
);

    logic [RATW-1:0] ratio_reg;
    logic            front_ready;
    logic            pose_valid, pose_take;
    pose_t           pose;
    logic            col_valid;
    col_t            col_word;
    logic            ent_valid;
    ent_word_t       ent_word;
    out_t [5:0]      rows;

    assign cfg_ready = 1'b1;
    assign busy      = !front_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ratio_reg <= RATIO_RESET;
        else if (cfg_valid && cfg_ready)
            ratio_reg <= cfg_data;
    end

    bej_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_ready  (front_ready),
        .qx        (quat_x),
        .qy        (quat_y),
        .qz        (quat_z),
        .qw        (quat_w),
        .px        (pos_x),
        .py        (pos_y),
        .pz        (pos_z),
        .mask      (active_mask),
        .out_valid (pose_valid),
        .out_take  (pose_take),
        .out_pose  (pose)
    );

    bej_seq #(
        .EXT_COLUMNS (EXT_COLUMNS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pose_valid),
        .in_take   (pose_take),
        .in_pose   (pose),
        .col_valid (col_valid),
        .col_word  (col_word)
    );

    bej_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (col_valid),
        .in_col    (col_word),
        .out_valid (ent_valid),
        .out_word  (ent_word)
    );

    bej_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ent_valid),
        .in_word   (ent_word),
        .ratio     (ratio_reg),
        .out_valid (result_valid),
        .out_col   (column),
        .out_last  (last_column),
        .out_e     (rows)
    );

    assign row_vx = rows[0];
    assign row_vy = rows[1];
    assign row_vz = rows[2];
    assign row_wx = rows[3];
    assign row_wy = rows[4];
    assign row_wz = rows[5];

    a_top_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_column) |-> (column == CW'(EXT_COLUMNS - 1)))
        else $error("last column flag on the wrong column");

    a_top_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_column) |=>
        (result_valid && column == $past(column) + CW'(1)))
        else $error("column run broken before its last column");

endmodule

// ===== verif/base_extension_jacobian_tb.sv =====
// ============================================================================
// base_extension_jacobian_tb - self-checking bench for the extension Jacobian
// Drives poses through the start/busy port with random gaps. An in-bench
// predictor computes the six columns expected for each pose. Every column
// strobe is checked field by field against the oldest pending prediction,
// across several extension ratio settings including both extremes.
// ============================================================================
module base_extension_jacobian_tb
    import bej_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAST_COL = EXT_COLUMNS_DEF - 1;

    typedef struct {
        quat_t         qx;
        quat_t         qy;
        quat_t         qz;
        quat_t         qw;
        pos_t          px;
        pos_t          py;
        pos_t          pz;
        logic [MW-1:0] mask;
    } pose_word_t;

    typedef struct {
        logic [CW-1:0] col;
        out_t          vx;
        out_t          vy;
        out_t          vz;
        out_t          wx;
        out_t          wy;
        out_t          wz;
        logic          last;
    } column_word_t;

    // Predicts the columns of each accepted pose and checks the strobed ones.
    class jacobian_ledger;
        longint unsigned ratio;
        column_word_t    pending_columns[$];
        int              failures;
        int              columns_seen;

        function new();
            ratio        = RATIO_RESET;
            failures     = 0;
            columns_seen = 0;
        endfunction

        function longint half_up14(longint v);
            return (v + 64'sd8192) >>> 14;
        endfunction

        function out_t scale_entry(longint e);
            longint v;
            v = half_up14(e * longint'(ratio));
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            return out_t'(v);
        endfunction

        function void note_pose(pose_word_t pw);
            longint       x, y, z, w;
            longint       pos[3];
            longint       r[3][3];
            longint       p[3];
            longint       lin[3];
            longint       ang[3];
            longint       one;
            column_word_t cw;
            x = pw.qx;
            y = pw.qy;
            z = pw.qz;
            w = pw.qw;
            pos[0] = pw.px;
            pos[1] = pw.py;
            pos[2] = pw.pz;
            one = 64'sd1 <<< 28;
            r[0][0] = half_up14(one - 2 * (y * y + z * z));
            r[0][1] = half_up14(2 * (x * y - z * w));
            r[0][2] = half_up14(2 * (x * z + y * w));
            r[1][0] = half_up14(2 * (x * y + z * w));
            r[1][1] = half_up14(one - 2 * (x * x + z * z));
            r[1][2] = half_up14(2 * (y * z - x * w));
            r[2][0] = half_up14(2 * (x * z - y * w));
            r[2][1] = half_up14(2 * (y * z + x * w));
            r[2][2] = half_up14(one - 2 * (x * x + y * y));
            for (int i = 0; i < 3; i++)
                p[i] = half_up14(r[i][0] * pos[0] + r[i][1] * pos[1] + r[i][2] * pos[2]);
            for (int c = 0; c < EXT_COLUMNS_DEF; c++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lin[i] = 0;
                    ang[i] = 0;
                end
                if (pw.mask[c])
                begin
                    if (c < 3)
                    begin
                        for (int i = 0; i < 3; i++)
                            lin[i] = r[i][c] * 4;
                    end
                    else
                    begin
                        lin[0] = half_up14(r[1][c-3] * p[2] - r[2][c-3] * p[1]);
                        lin[1] = half_up14(r[2][c-3] * p[0] - r[0][c-3] * p[2]);
                        lin[2] = half_up14(r[0][c-3] * p[1] - r[1][c-3] * p[0]);
                        for (int i = 0; i < 3; i++)
                            ang[i] = r[i][c-3] * 4;
                    end
                end
                cw.col  = CW'(c);
                cw.vx   = scale_entry(lin[0]);
                cw.vy   = scale_entry(lin[1]);
                cw.vz   = scale_entry(lin[2]);
                cw.wx   = scale_entry(ang[0]);
                cw.wy   = scale_entry(ang[1]);
                cw.wz   = scale_entry(ang[2]);
                cw.last = (c == LAST_COL);
                pending_columns.insert(pending_columns.size(), cw);
            end
        endfunction

        function void field_ok(string name, longint want, longint got, int col);
            if (want != got)
            begin
                failures++;
                $error("column %0d field %s: expected %0d, actual %0d", col, name, want, got);
            end
        endfunction

        function void check_column(logic [CW-1:0] col, out_t vx, out_t vy, out_t vz,
                                   out_t wx, out_t wy, out_t wz, logic last);
            column_word_t cw;
            columns_seen++;
            if (pending_columns.size() == 0)
            begin
                failures++;
                $error("column %0d strobed with no prediction pending", col);
                return;
            end
            cw = pending_columns.pop_front();
            field_ok("column", cw.col, col, cw.col);
            field_ok("row_vx", cw.vx, vx, cw.col);
            field_ok("row_vy", cw.vy, vy, cw.col);
            field_ok("row_vz", cw.vz, vz, cw.col);
            field_ok("row_wx", cw.wx, wx, cw.col);
            field_ok("row_wy", cw.wy, wy, cw.col);
            field_ok("row_wz", cw.wz, wz, cw.col);
            field_ok("last_column", cw.last, last, cw.col);
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    quat_t           quat_x;
    quat_t           quat_y;
    quat_t           quat_z;
    quat_t           quat_w;
    pos_t            pos_x;
    pos_t            pos_y;
    pos_t            pos_z;
    logic [MW-1:0]   active_mask;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [RATW-1:0] cfg_data;
    logic            result_valid;
    logic [CW-1:0]   column;
    out_t            row_vx;
    out_t            row_vy;
    out_t            row_vz;
    out_t            row_wx;
    out_t            row_wy;
    out_t            row_wz;
    logic            last_column;

    jacobian_ledger ledger = new();
    int             poses_sent;
    int             ratio_writes;

    base_extension_jacobian u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .quat_w       (quat_w),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .active_mask  (active_mask),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .column       (column),
        .row_vx       (row_vx),
        .row_vy       (row_vy),
        .row_vz       (row_vz),
        .row_wx       (row_wx),
        .row_wy       (row_wy),
        .row_wz       (row_wz),
        .last_column  (last_column)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            ledger.check_column(column, row_vx, row_vy, row_vz,
                                row_wx, row_wy, row_wz, last_column);
    end

    function automatic pose_word_t make_pose(int qx, int qy, int qz, int qw,
                                             int px, int py, int pz, int mask);
        pose_word_t pw;
        pw.qx   = quat_t'(qx);
        pw.qy   = quat_t'(qy);
        pw.qz   = quat_t'(qz);
        pw.qw   = quat_t'(qw);
        pw.px   = pos_t'(px);
        pw.py   = pos_t'(py);
        pw.pz   = pos_t'(pz);
        pw.mask = MW'(mask);
        return pw;
    endfunction

    function automatic int rand_span(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic pose_word_t random_pose();
        pose_word_t pw;
        real        a, b, c, d, n;
        int         kind;
        kind = $urandom_range(99);
        if (kind < 65)
        begin
            // unit quaternion, the normal operating case
            a = $itor(rand_span(-10000, 10000));
            b = $itor(rand_span(-10000, 10000));
            c = $itor(rand_span(-10000, 10000));
            d = $itor(rand_span(-10000, 10000));
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0)
            begin
                a = 0.0;
                b = 0.0;
                c = 0.0;
                d = 1.0;
                n = 1.0;
            end
            pw = make_pose($rtoi(a / n * 16384.0), $rtoi(b / n * 16384.0),
                           $rtoi(c / n * 16384.0), $rtoi(d / n * 16384.0), 0, 0, 0, 0);
        end
        else if (kind < 90)
            pw = make_pose(rand_span(-16384, 16384), rand_span(-16384, 16384),
                           rand_span(-16384, 16384), rand_span(-16384, 16384), 0, 0, 0, 0);
        else
            pw = make_pose($urandom, $urandom, $urandom, $urandom, 0, 0, 0, 0);
        if ($urandom_range(3) == 0)
        begin
            pw.px = pos_t'($urandom);
            pw.py = pos_t'($urandom);
            pw.pz = pos_t'($urandom);
        end
        else
        begin
            pw.px = pos_t'(rand_span(-1048576, 1048576));
            pw.py = pos_t'(rand_span(-1048576, 1048576));
            pw.pz = pos_t'(rand_span(-1048576, 1048576));
        end
        pw.mask = ($urandom_range(2) == 0) ? {MW{1'b1}} : MW'($urandom);
        return pw;
    endfunction

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return 0;
        else if (roll < 85)
            return rand_span(1, 3);
        else if (roll < 97)
            return rand_span(4, 10);
        else
            return rand_span(20, 60);
    endfunction

    task automatic idle_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic send_pose(pose_word_t pw);
        @(negedge clk);
        start       = 1'b1;
        quat_x      = pw.qx;
        quat_y      = pw.qy;
        quat_z      = pw.qz;
        quat_w      = pw.qw;
        pos_x       = pw.px;
        pos_y       = pw.py;
        pos_z       = pw.pz;
        active_mask = pw.mask;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        ledger.note_pose(pw);
        poses_sent++;
    endtask

    // hold until every predicted column has come, then let the pipe settle
    task automatic drain_columns();
        idle_sender(1);
        while (ledger.pending_columns.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_ratio(logic [RATW-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        ledger.ratio = value;
        ratio_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_random_phase(int count, bit hold_midway);
        bit burst;
        burst = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
                burst = ($urandom_range(3) == 0);
            if (hold_midway && i == count / 2)
                drain_columns();
            send_pose(random_pose());
            if (!burst)
                idle_sender(gap_length());
        end
        drain_columns();
    endtask

    task automatic run_directed();
        pose_word_t list[$];
        list.insert(list.size(),
                    make_pose(0, 0, 0, 16384, 65536, 131072, -196608, 6'h3F));
        list.insert(list.size(),
                    make_pose(0, 0, 0, 16384, 8388607, 8388607, 8388607, 6'h3F));
        list.insert(list.size(),
                    make_pose(0, 0, 0, 16384, -8388608, -8388608, -8388608, 6'h3F));
        list.insert(list.size(),
                    make_pose(16384, 0, 0, 0, 65536, 131072, 196608, 6'h3F));
        list.insert(list.size(),
                    make_pose(0, 16384, 0, 0, 65536, 131072, 196608, 6'h3F));
        list.insert(list.size(),
                    make_pose(0, 0, 16384, 0, 65536, 131072, 196608, 6'h3F));
        list.insert(list.size(),
                    make_pose(0, 0, 0, -16384, 8388607, -8388608, 1, 6'h3F));
        list.insert(list.size(),
                    make_pose(-16384, 0, 0, 0, -8388608, 8388607, -1, 6'h3F));
        list.insert(list.size(),
                    make_pose(0, 0, 11585, 11585, 65536, 0, 0, 6'h3F));
        // inactive columns must still be emitted as zeros
        list.insert(list.size(),
                    make_pose(8192, 8192, 8192, 8192, 300000, -200000, 100000, 6'h00));
        for (int b = 0; b < MW; b++)
            list.insert(list.size(),
                        make_pose(8192, -8192, 8192, 8192, 300000, -200000, 100000, 1 << b));
        // non-unit quaternion, used without normalizing
        list.insert(list.size(),
                    make_pose(16384, 16384, 16384, 16384, 65536, 65536, 65536, 6'h3F));
        // bit patterns outside the stated range drive the saturation path
        list.insert(list.size(),
                    make_pose(-32768, -32768, -32768, -32768,
                              8388607, 8388607, 8388607, 6'h3F));
        list.insert(list.size(),
                    make_pose(32767, 32767, 32767, 32767,
                              -8388608, -8388608, 8388607, 6'h3F));
        list.insert(list.size(),
                    make_pose(32767, -32768, 12345, -4321, 8388607, -8388608, 777, 6'h2A));
        foreach (list[i])
        begin
            send_pose(list[i]);
            idle_sender(i % 3);
        end
        drain_columns();
    endtask

    initial
    begin
        logic [RATW-1:0] ratio_plan[$];
        rst_n        = 1'b0;
        start        = 1'b0;
        quat_x       = '0;
        quat_y       = '0;
        quat_z       = '0;
        quat_w       = '0;
        pos_x        = '0;
        pos_y        = '0;
        pos_z        = '0;
        active_mask  = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        poses_sent   = 0;
        ratio_writes = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        ratio_plan = '{16'd0, 16'd65535, 16'd1, 16'd8192, RATW'($urandom), 16'd49152,
                       RATW'($urandom), RATIO_RESET};
        foreach (ratio_plan[i])
        begin
            write_ratio(ratio_plan[i]);
            run_random_phase(58, i == 2);
        end

        while (ledger.pending_columns.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d poses and %0d columns over %0d ratio writes,",
                 poses_sent, ledger.columns_seen, ratio_writes);
        $display("ratios 0 and 65535 included, with unit, non-unit and raw quaternions.");
        if (ledger.failures == 0 && ledger.pending_columns.size() == 0)
            $display("base_extension_jacobian verification clean");
        else
            $display("base_extension_jacobian verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("base_extension_jacobian verification failed");
        $finish;
    end

endmodule

// ===== base_extension_jacobian.f =====
sv/bej_pkg.sv
sv/bej_front.sv
sv/bej_seq.sv
sv/bej_cross.sv
sv/bej_scale.sv
sv/base_extension_jacobian.sv
verif/base_extension_jacobian_tb.sv
